// File: sv/euler_xyz_point_rotation_top_macros.svh
// ----------------------------------------------------------------------------
// euler xyz point rotation: assertion macros
// Shared concurrent assertion forms, sampled on clk; all but the always form use rst_n as reset.
// ----------------------------------------------------------------------------
`ifndef EULER_XYZ_POINT_ROTATION_TOP_MACROS_SVH
`define EULER_XYZ_POINT_ROTATION_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define EXR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define EXR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checked at every edge, reset included
`define EXR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: sv/exr_pkg.sv
// ----------------------------------------------------------------------------
// exr_pkg
// Widths, angle constants and shared types of the euler xyz point rotation.
// ----------------------------------------------------------------------------
package exr_pkg;

    // field widths
    localparam int COORD_W     = 32;
    localparam int ANGLE_W     = 16;
    localparam int TRIG_FRAC   = 16;
    localparam int TRIG_W      = TRIG_FRAC + 2;

    // beat layout
    localparam int PT_OFS      = 3 * ANGLE_W;
    localparam int IN_TDATA_W  = 3 * ANGLE_W + 3 * COORD_W;
    localparam int OUT_TDATA_W = 3 * COORD_W;

    // angle units: 1/64 degree
    localparam int QUARTER_UNITS = 5760;
    localparam int FULL_UNITS    = 4 * QUARTER_UNITS;
    localparam int ANGLE_RED_W   = 15;
    localparam int QUARTER_W     = 13;

    // quarter units = ODD_DIVISOR << PRE_SHIFT
    localparam int PRE_SHIFT     = 7;
    localparam int ODD_DIVISOR   = 45;

    // half pi in q30 for the sine table
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // pipeline depths
    localparam int TRIG_LAT = 6;
    localparam int ROT_LAT  = 2;

    // cosine and sine factors of one angle, 16 fractional bits
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_f;
        logic signed [TRIG_W-1:0] sin_f;
    } trig_t;

endpackage

// File: sv/exr_trig.sv
// ----------------------------------------------------------------------------
// exr_trig
// Six-stage pipeline from an angle in 1/64 degree to its cosine and sine,
// read from a quarter-wave sine table.
// ----------------------------------------------------------------------------
module exr_trig #(
    parameter int ENTRIES = 1024
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [exr_pkg::ANGLE_W-1:0]  angle,
    output exr_pkg::trig_t                      f
);
    import exr_pkg::*;

    localparam int V_W   = $clog2(QUARTER_UNITS * ENTRIES + QUARTER_UNITS / 2 + 1);
    localparam int U_W   = V_W - PRE_SHIFT;
    localparam int RECIP = (2 ** U_W) / ODD_DIVISOR;
    localparam int RC_W  = $clog2(RECIP + 1);
    localparam int P_W   = U_W + RC_W;
    localparam int IDX_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = ANGLE_W + 1;

    typedef logic [TRIG_FRAC:0] rom_word_t;
    typedef rom_word_t rom_t [0:ENTRIES];

    typedef struct packed {
        logic                 neg;
        logic [QUARTER_W-1:0] t;
    } quad_t;

    // sine of 0..90 degrees, taylor series in q30 rounded to 16 bits
    function automatic rom_t build_rom();
        rom_t   rom;
        longint x;
        longint x2;
        longint term;
        longint prod;
        longint sum;
        longint v;
        for (int i = 0; i <= ENTRIES; i++)
        begin
            x    = (HALF_PI_Q30 * longint'(i)) / ENTRIES;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= 8; k++)
            begin
                prod = (term * x2) >>> 30;
                // next term divides by (2k)(2k+1)
                case (k)
                    1:       term = prod / 6;
                    2:       term = prod / 20;
                    3:       term = prod / 42;
                    4:       term = prod / 72;
                    5:       term = prod / 110;
                    6:       term = prod / 156;
                    7:       term = prod / 210;
                    default: term = prod / 272;
                endcase
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum < 0)
                sum = 0;
            v = (sum + (longint'(1) <<< 13)) >>> 14;
            if (v > 65536)
                v = 65536;
            rom[i] = rom_word_t'(v);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // reduce to 0 .. full turn
    function automatic logic [ANGLE_RED_W-1:0] wrap_angle(input logic signed [EXT_W-1:0] a);
        logic signed [EXT_W-1:0] full_s;
        logic signed [EXT_W-1:0] w1;
        logic signed [EXT_W-1:0] w2;
        full_s = EXT_W'(FULL_UNITS);
        if (a < 0)
            w1 = a + full_s;
        else if (a >= full_s)
            w1 = a - full_s;
        else
            w1 = a;
        if (w1 < 0)
            w2 = w1 + full_s;
        else
            w2 = w1;
        return w2[ANGLE_RED_W-1:0];
    endfunction

    // quadrant split: table offset and sign
    function automatic quad_t split_quad(input logic [ANGLE_RED_W-1:0] r);
        logic [1:0]             q;
        logic [ANGLE_RED_W-1:0] base;
        logic [QUARTER_W-1:0]   p;
        quad_t                  res;
        if (r >= ANGLE_RED_W'(3 * QUARTER_UNITS))
            q = 2'd3;
        else if (r >= ANGLE_RED_W'(2 * QUARTER_UNITS))
            q = 2'd2;
        else if (r >= ANGLE_RED_W'(QUARTER_UNITS))
            q = 2'd1;
        else
            q = 2'd0;
        case (q)
            2'd0:    base = '0;
            2'd1:    base = ANGLE_RED_W'(QUARTER_UNITS);
            2'd2:    base = ANGLE_RED_W'(2 * QUARTER_UNITS);
            default: base = ANGLE_RED_W'(3 * QUARTER_UNITS);
        endcase
        p       = QUARTER_W'(r - base);
        res.neg = q[1];
        res.t   = q[0] ? QUARTER_W'(QUARTER_UNITS) - p : p;
        return res;
    endfunction

    logic signed [EXT_W-1:0]  a_ext;
    logic signed [EXT_W-1:0]  a_cos;
    logic [ANGLE_RED_W-1:0]   rs_reg, rc_reg;
    quad_t                    qs_reg, qc_reg;
    quad_t                    qs_next, qc_next;
    logic [V_W-1:0]           vs_next, vc_next;
    logic [U_W-1:0]           us_reg, uc_reg;
    logic                     ns3_reg, nc3_reg;
    logic [P_W-1:0]           ps_reg, pc_reg;
    logic [U_W-1:0]           us4_reg, uc4_reg;
    logic                     ns4_reg, nc4_reg;
    logic [IDX_W-1:0]         q0s, q0c;
    logic [U_W-1:0]           rems, remc;
    logic [IDX_W-1:0]         is_next, ic_next;
    logic [IDX_W-1:0]         is_reg, ic_reg;
    logic                     ns5_reg, nc5_reg;
    logic signed [TRIG_W-1:0] sin_next, cos_next;
    trig_t                    f_reg;

    // stage 1: angle reduction for sine and cosine
    assign a_ext = {angle[ANGLE_W-1], angle};
    assign a_cos = a_ext + EXT_W'(QUARTER_UNITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rs_reg <= wrap_angle(a_ext);
            rc_reg <= wrap_angle(a_cos);
        end
    end

    // stage 2: quadrant split
    assign qs_next = split_quad(rs_reg);
    assign qc_next = split_quad(rc_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qs_reg <= qs_next;
            qc_reg <= qc_next;
        end
    end

    // stage 3: scale offset to table steps, drop the power-of-two part of the divisor
    assign vs_next = V_W'(qs_reg.t) * V_W'(ENTRIES) + V_W'(QUARTER_UNITS / 2);
    assign vc_next = V_W'(qc_reg.t) * V_W'(ENTRIES) + V_W'(QUARTER_UNITS / 2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            us_reg  <= vs_next[V_W-1:PRE_SHIFT];
            uc_reg  <= vc_next[V_W-1:PRE_SHIFT];
            ns3_reg <= qs_reg.neg;
            nc3_reg <= qc_reg.neg;
        end
    end

    // stage 4: reciprocal multiply for the divide by the odd factor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg  <= P_W'(us_reg) * P_W'(RECIP);
            pc_reg  <= P_W'(uc_reg) * P_W'(RECIP);
            us4_reg <= us_reg;
            uc4_reg <= uc_reg;
            ns4_reg <= ns3_reg;
            nc4_reg <= nc3_reg;
        end
    end

    // stage 5: quotient estimate is exact or one low, fix with one compare
    assign q0s  = IDX_W'(ps_reg >> U_W);
    assign q0c  = IDX_W'(pc_reg >> U_W);
    assign rems = us4_reg - U_W'(q0s) * U_W'(ODD_DIVISOR);
    assign remc = uc4_reg - U_W'(q0c) * U_W'(ODD_DIVISOR);

    always_comb
    begin
        is_next = q0s;
        ic_next = q0c;
        if (rems >= U_W'(ODD_DIVISOR))
            is_next = q0s + IDX_W'(1);
        if (remc >= U_W'(ODD_DIVISOR))
            ic_next = q0c + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            is_reg  <= is_next;
            ic_reg  <= ic_next;
            ns5_reg <= ns4_reg;
            nc5_reg <= nc4_reg;
        end
    end

    // stage 6: table read and sign
    always_comb
    begin
        sin_next = TRIG_W'(signed'({1'b0, SINE_ROM[is_reg]}));
        cos_next = TRIG_W'(signed'({1'b0, SINE_ROM[ic_reg]}));
        if (ns5_reg)
            sin_next = -sin_next;
        if (nc5_reg)
            cos_next = -cos_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg.sin_f <= sin_next;
            f_reg.cos_f <= cos_next;
        end
    end

    assign f = f_reg;

endmodule

// File: sv/exr_rot.sv
// ----------------------------------------------------------------------------
// exr_rot
// Two-stage counterclockwise rotation of a coordinate pair: products, then
// sums rounded half up by the 16 fractional bits of the factors.
// ----------------------------------------------------------------------------
module exr_rot #(
    parameter int IN_W = 32
) (
    input  logic                   clk,
    input  logic                   en,
    input  exr_pkg::trig_t         f,
    input  logic signed [IN_W-1:0] a,
    input  logic signed [IN_W-1:0] b,
    output logic signed [IN_W+1:0] na,
    output logic signed [IN_W+1:0] nb
);
    import exr_pkg::*;

    localparam int P_W = IN_W + TRIG_W;
    localparam int S_W = P_W + 1;

    logic signed [P_W-1:0]  ca_reg, sb_reg, sa_reg, cb_reg;
    logic signed [S_W-1:0]  da, db;
    logic signed [S_W-1:0]  sha, shb;
    logic signed [IN_W+1:0] na_reg, nb_reg;

    // stage 1: four products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg <= P_W'(f.cos_f) * P_W'(a);
            sb_reg <= P_W'(f.sin_f) * P_W'(b);
            sa_reg <= P_W'(f.sin_f) * P_W'(a);
            cb_reg <= P_W'(f.cos_f) * P_W'(b);
        end
    end

    // stage 2: combine and round toward plus infinity on ties
    assign da  = S_W'(ca_reg) - S_W'(sb_reg) + S_W'(1 <<< (TRIG_FRAC - 1));
    assign db  = S_W'(sa_reg) + S_W'(cb_reg) + S_W'(1 <<< (TRIG_FRAC - 1));
    assign sha = da >>> TRIG_FRAC;
    assign shb = db >>> TRIG_FRAC;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg <= sha[IN_W+1:0];
            nb_reg <= shb[IN_W+1:0];
        end
    end

    assign na = na_reg;
    assign nb = nb_reg;

endmodule

// File: sv/euler_xyz_point_rotation_top.sv
// ----------------------------------------------------------------------------
// euler_xyz_point_rotation_top
// Rotates a Q16.16 point about X, then Y, then Z by three angles given in
// 1/64 degree; results saturate to the signed 32-bit range.
//
//  channel | dir | fields (low bit first)
//  s_*     | in  | tdata: angle_about_x, angle_about_y, angle_about_z,
//          |     |        point_x, point_y, point_z
//  m_*     | out | tdata: rotated_x, rotated_y, rotated_z
//
// One beat per cycle while m_tready does not hold the pipeline; each beat passes
// through the sine/cosine lookup, then the three pair rotations and then
// saturation into the output register.
// rst_n clears all valid bits; data registers are not reset.
// The whole pipeline holds while a result waits and m_tready is low.
// ----------------------------------------------------------------------------
module euler_xyz_point_rotation_top #(
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // angle_about_x, angle_about_y, angle_about_z, point_x, point_y, point_z
    input  logic [exr_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [exr_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import exr_pkg::*;

    localparam int LAT   = TRIG_LAT + 3 * ROT_LAT + 1;
    localparam int W1    = COORD_W + 2;
    localparam int W2    = COORD_W + 4;
    localparam int W3    = COORD_W + 6;

    logic                      en;
    logic [LAT-1:0]            valid_reg;

    logic signed [ANGLE_W-1:0] ax, ay, az;
    logic signed [COORD_W-1:0] px, py, pz;
    trig_t                     fx, fy, fz;

    logic signed [COORD_W-1:0] px_dly_reg [0:TRIG_LAT-1];
    logic signed [COORD_W-1:0] py_dly_reg [0:TRIG_LAT-1];
    logic signed [COORD_W-1:0] pz_dly_reg [0:TRIG_LAT-1];
    logic signed [COORD_W-1:0] x0_dly_reg [0:ROT_LAT-1];
    trig_t                     fy_dly_reg [0:ROT_LAT-1];
    trig_t                     fz_dly_reg [0:2*ROT_LAT-1];
    logic signed [W1-1:0]      y1_dly_reg [0:ROT_LAT-1];
    logic signed [W2-1:0]      z2_dly_reg [0:ROT_LAT-1];

    logic signed [W1-1:0]      y1, z1;
    logic signed [W2-1:0]      z2, x2;
    logic signed [W3-1:0]      x3, y3;

    logic [COORD_W-1:0]        rx_reg, ry_reg, rz_reg;

    // clamp a wide coordinate to the signed 32-bit range
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [W3-1:0] v);
        logic [COORD_W-1:0] res;
        if (!v[W3-1] && (|v[W3-2:COORD_W-1]))
            res = {1'b0, {(COORD_W-1){1'b1}}};
        else if (v[W3-1] && !(&v[W3-2:COORD_W-1]))
            res = {1'b1, {(COORD_W-1){1'b0}}};
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

    // global advance: move when the output register is free or being taken
    assign en       = !valid_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[LAT-2:0], s_tvalid};
    end

    // input beat fields
    assign ax = s_tdata[ANGLE_W-1:0];
    assign ay = s_tdata[2*ANGLE_W-1:ANGLE_W];
    assign az = s_tdata[3*ANGLE_W-1:2*ANGLE_W];
    assign px = s_tdata[PT_OFS+COORD_W-1:PT_OFS];
    assign py = s_tdata[PT_OFS+2*COORD_W-1:PT_OFS+COORD_W];
    assign pz = s_tdata[PT_OFS+3*COORD_W-1:PT_OFS+2*COORD_W];

    // factor lookups, all three angles in parallel
    exr_trig #(.ENTRIES(SINE_TABLE_ENTRIES)) u_trig_x (
        .clk   (clk),
        .en    (en),
        .angle (ax),
        .f     (fx)
    );

    exr_trig #(.ENTRIES(SINE_TABLE_ENTRIES)) u_trig_y (
        .clk   (clk),
        .en    (en),
        .angle (ay),
        .f     (fy)
    );

    exr_trig #(.ENTRIES(SINE_TABLE_ENTRIES)) u_trig_z (
        .clk   (clk),
        .en    (en),
        .angle (az),
        .f     (fz)
    );

    // alignment delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_dly_reg[0] <= px;
            py_dly_reg[0] <= py;
            pz_dly_reg[0] <= pz;
            for (int i = 1; i < TRIG_LAT; i++)
            begin
                px_dly_reg[i] <= px_dly_reg[i-1];
                py_dly_reg[i] <= py_dly_reg[i-1];
                pz_dly_reg[i] <= pz_dly_reg[i-1];
            end
            x0_dly_reg[0] <= px_dly_reg[TRIG_LAT-1];
            fy_dly_reg[0] <= fy;
            y1_dly_reg[0] <= y1;
            z2_dly_reg[0] <= z2;
            for (int i = 1; i < ROT_LAT; i++)
            begin
                x0_dly_reg[i] <= x0_dly_reg[i-1];
                fy_dly_reg[i] <= fy_dly_reg[i-1];
                y1_dly_reg[i] <= y1_dly_reg[i-1];
                z2_dly_reg[i] <= z2_dly_reg[i-1];
            end
            fz_dly_reg[0] <= fz;
            for (int i = 1; i < 2 * ROT_LAT; i++)
                fz_dly_reg[i] <= fz_dly_reg[i-1];
        end
    end

    // about x: (y, z) turns
    exr_rot #(.IN_W(COORD_W)) u_rot_x (
        .clk (clk),
        .en  (en),
        .f   (fx),
        .a   (py_dly_reg[TRIG_LAT-1]),
        .b   (pz_dly_reg[TRIG_LAT-1]),
        .na  (y1),
        .nb  (z1)
    );

    // about y: (z, x) turns
    exr_rot #(.IN_W(W1)) u_rot_y (
        .clk (clk),
        .en  (en),
        .f   (fy_dly_reg[ROT_LAT-1]),
        .a   (z1),
        .b   (W1'(x0_dly_reg[ROT_LAT-1])),
        .na  (z2),
        .nb  (x2)
    );

    // about z: (x, y) turns
    exr_rot #(.IN_W(W2)) u_rot_z (
        .clk (clk),
        .en  (en),
        .f   (fz_dly_reg[2*ROT_LAT-1]),
        .a   (x2),
        .b   (W2'(y1_dly_reg[ROT_LAT-1])),
        .na  (x3),
        .nb  (y3)
    );

    // output register with saturation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= sat_coord(x3);
            ry_reg <= sat_coord(y3);
            rz_reg <= sat_coord(W3'(z2_dly_reg[ROT_LAT-1]));
        end
    end

    assign m_tdata = {rz_reg, ry_reg, rx_reg};

endmodule

// File: sv/exr_checker.sv
// ----------------------------------------------------------------------------
// exr_checker
// Port-level checks of the euler xyz point rotation, bound to the top level.
// ----------------------------------------------------------------------------
`include "euler_xyz_point_rotation_top_macros.svh"

module exr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    // angle_about_x, angle_about_y, angle_about_z, point_x, point_y, point_z
    input logic [exr_pkg::IN_TDATA_W-1:0]    s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    // rotated_x, rotated_y, rotated_z
    input logic [exr_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import exr_pkg::*;

    // a stalled result beat holds
    `EXR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    // input side opens exactly when the output register can move
    `EXR_ASSERT_NOW(a_ready_link, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready out of step with output")

    // a new result only appears after the pipeline advanced
    `EXR_ASSERT_NOW(a_out_rise, $rose(m_tvalid), $past(s_tready), "result appeared without a pipeline step")

    // nothing is offered while in reset
    `EXR_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind euler_xyz_point_rotation_top exr_checker u_exr_checker (.*);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: euler xyz point rotation testbench
// Streams points and angle triples into the rotation pipeline, predicts each
// rotated point with an independent fixed-point model (own quarter-wave sine
// table, three rounded pair rotations, final saturation) and checks every
// output beat in order, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;

    import exr_pkg::*;

    localparam int     SINE_ENTRIES = 1024;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     DRAIN_CYCLES = 30;
    localparam int     COORD_MAX    = 32'sh7fff_ffff;
    localparam int     COORD_MIN    = 32'sh8000_0000;
    localparam int     ONE_Q16      = 32'sd65536;
    localparam longint ROUND_HALF   = 64'sd1 <<< (TRIG_FRAC - 1);

    // one input beat, fields in natural order
    typedef struct packed {
        logic signed [ANGLE_W-1:0] ax;
        logic signed [ANGLE_W-1:0] ay;
        logic signed [ANGLE_W-1:0] az;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } point_beat_t;

    // one rotated point
    typedef struct packed {
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
        logic [COORD_W-1:0] rz;
    } rotated_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    longint   sine_table [0:SINE_ENTRIES];
    rotated_t rotated_q[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       src_idle_on    = 1'b0;
    bit       sink_idle_on   = 1'b0;

    euler_xyz_point_rotation_top #(
        .SINE_TABLE_ENTRIES(SINE_ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, rotated_q.size());
            $display("** euler_xyz_point_rotation_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // rotation predictor
    // ------------------------------------------------------------------------

    // quarter-wave sine table: 9-term taylor series in q30, rounded to q16
    function automatic void build_sine_table();
        longint x;
        longint x2;
        longint term;
        longint acc;
        longint v;
        int     i;
        longint k;
        for (i = 0; i <= SINE_ENTRIES; i++)
        begin
            x    = (HALF_PI_Q30 * i) / SINE_ENTRIES;
            x2   = (x * x) >>> 30;
            term = x;
            acc  = x;
            for (k = 1; k <= 8; k++)
            begin
                term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
                if (k[0])
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            if (acc < 0)
                acc = 0;
            v = (acc + (64'sd1 <<< 13)) >>> 14;
            if (v > ONE_Q16)
                v = ONE_Q16;
            sine_table[i] = v;
        end
    endfunction

    // table value for an offset 0..quarter within one quadrant
    function automatic longint quarter_sine(longint t);
        longint idx;
        idx = (t * SINE_ENTRIES + QUARTER_UNITS / 2) / QUARTER_UNITS;
        if (idx < 0)
            idx = 0;
        if (idx > SINE_ENTRIES)
            idx = SINE_ENTRIES;
        return sine_table[int'(idx)];
    endfunction

    // sine of an angle in 1/64 degree, any value
    function automatic longint sine_units(longint angle);
        longint r;
        longint q;
        longint p;
        r = angle % FULL_UNITS;
        if (r < 0)
            r = r + FULL_UNITS;
        q = r / QUARTER_UNITS;
        p = r % QUARTER_UNITS;
        case (q)
            0:       return quarter_sine(p);
            1:       return quarter_sine(QUARTER_UNITS - p);
            2:       return -quarter_sine(p);
            default: return -quarter_sine(QUARTER_UNITS - p);
        endcase
    endfunction

    // counterclockwise turn of (a, b), rounded half up by the trig fraction
    function automatic void turn_pair(inout longint a, inout longint b, input longint angle);
        longint c;
        longint s;
        longint na;
        c  = sine_units(angle + QUARTER_UNITS);
        s  = sine_units(angle);
        na = (c * a - s * b + ROUND_HALF) >>> TRIG_FRAC;
        b  = (s * a + c * b + ROUND_HALF) >>> TRIG_FRAC;
        a  = na;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v[COORD_W-1:0];
    endfunction

    // out = rz * ry * rx * in
    function automatic rotated_t rotate_xyz(point_beat_t b);
        longint   x;
        longint   y;
        longint   z;
        rotated_t r;
        x = b.px;
        y = b.py;
        z = b.pz;
        turn_pair(y, z, b.ax);
        turn_pair(z, x, b.ay);
        turn_pair(x, y, b.az);
        r.rx = clamp_coord(x);
        r.ry = clamp_coord(y);
        r.rz = clamp_coord(z);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic point_beat_t make_point(int ax, int ay, int az, int px, int py, int pz);
        point_beat_t b;
        b.ax = ax[ANGLE_W-1:0];
        b.ay = ay[ANGLE_W-1:0];
        b.az = az[ANGLE_W-1:0];
        b.px = px;
        b.py = py;
        b.pz = pz;
        return b;
    endfunction

    // mostly in range, some quadrant edges, some arbitrary 16-bit patterns
    function automatic int random_angle();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 65535)) - 32768;
            1:       return int'($urandom_range(0, 8)) * QUARTER_UNITS - FULL_UNITS
                            + int'($urandom_range(0, 4)) - 2;
            default: return int'($urandom_range(0, 2 * FULL_UNITS)) - FULL_UNITS;
        endcase
    endfunction

    function automatic int random_coord();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return int'($urandom_range(0, 1 << 21)) - (1 << 20);
            3:
            begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MAX;
                    1:       return COORD_MIN;
                    2:       return -1;
                    default: return ONE_Q16;
                endcase
            end
            default: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
        endcase
    endfunction

    function automatic point_beat_t random_point();
        return make_point(random_angle(), random_angle(), random_angle(),
                          random_coord(), random_coord(), random_coord());
    endfunction

    // send one beat; called and returns at a rising edge
    task automatic send_point(input point_beat_t b);
        int gap;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b.pz, b.py, b.px, b.az, b.ay, b.ax};
        // ready is stable between edges, look at it mid-cycle
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        rotated_q.push_back(rotate_xyz(b));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (rotated_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // unit vectors through each quadrant and full turns
    task automatic test_axis_quadrants();
        send_point(make_point(0, 0, 0, 0, 0, 0));
        send_point(make_point(0, 0, QUARTER_UNITS, ONE_Q16, 0, 0));
        send_point(make_point(QUARTER_UNITS, 0, 0, 0, ONE_Q16, 0));
        send_point(make_point(0, QUARTER_UNITS, 0, 0, 0, ONE_Q16));
        send_point(make_point(2 * QUARTER_UNITS, 2 * QUARTER_UNITS, 2 * QUARTER_UNITS,
                              ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16));
        send_point(make_point(3 * QUARTER_UNITS, -QUARTER_UNITS, FULL_UNITS,
                              ONE_Q16, -ONE_Q16, ONE_Q16 / 2));
        send_point(make_point(-FULL_UNITS, FULL_UNITS, 0, 12345, -67890, 424242));
        send_point(make_point(1, -1, QUARTER_UNITS - 1, ONE_Q16, ONE_Q16, ONE_Q16));
    endtask

    // angle patterns outside one turn wrap modulo 360 degrees
    task automatic test_angle_wrap();
        send_point(make_point(32767, -32768, FULL_UNITS + 1, ONE_Q16, -ONE_Q16, 777777));
        send_point(make_point(-FULL_UNITS - 1, -1, 32767, -ONE_Q16, 3 * ONE_Q16, -5));
        send_point(make_point(-32768, 32767, -32768, COORD_MAX, 0, COORD_MIN));
    endtask

    // extreme coordinates, with and without growth past the 32-bit range
    task automatic test_saturation();
        send_point(make_point(0, 0, 0, COORD_MIN, COORD_MAX, -1));
        send_point(make_point(QUARTER_UNITS / 2, QUARTER_UNITS / 2, QUARTER_UNITS / 2,
                              COORD_MAX, COORD_MAX, COORD_MAX));
        send_point(make_point(QUARTER_UNITS / 2, -QUARTER_UNITS / 2, QUARTER_UNITS / 2,
                              COORD_MIN, COORD_MIN, COORD_MIN));
        send_point(make_point(0, 0, QUARTER_UNITS / 2, COORD_MAX, COORD_MIN, 0));
        send_point(make_point(2 * QUARTER_UNITS, 0, 0, COORD_MIN, COORD_MIN, COORD_MIN));
    endtask

    // tiny coordinates where rounding of negative halves shows
    task automatic test_rounding();
        send_point(make_point(64, 64, 64, -1, -1, -1));
        send_point(make_point(1, 1, 1, 1, -1, 1));
        send_point(make_point(-2880, 2880, -2880, -32768, 32768, -3));
        send_point(make_point(QUARTER_UNITS, QUARTER_UNITS, QUARTER_UNITS, -1, 1, -1));
    endtask

    // random items in chunks with changing idle patterns on both sides
    task automatic test_random_rotations();
        int chunk;
        int n;
        for (chunk = 0; chunk < 6; chunk++)
        begin
            src_idle_on  = (chunk % 3) != 2;
            sink_idle_on = (chunk % 2) == 0;
            for (n = 0; n < 150; n++)
                send_point(random_point());
        end
    endtask

    // the source holds off until the pipeline has emptied
    task automatic test_drain_pause();
        int round;
        int n;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (round = 0; round < 3; round++)
        begin
            for (n = 0; n < 30; n++)
                send_point(random_point());
            wait_drained();
        end
    endtask

    // back-to-back beats with the sink always ready
    task automatic test_full_rate();
        int n;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (n = 0; n < 300; n++)
            send_point(random_point());
    endtask

    // ------------------------------------------------------------------------
    // sink ready with random stall bursts
    // ------------------------------------------------------------------------
    initial
    begin : sink_driver
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 7) == 0)
            begin
                hold     = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result check, on the beat that the next rising edge accepts
    // ------------------------------------------------------------------------
    function automatic void compare_coord(string axis, logic [COORD_W-1:0] want,
                                          logic [COORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, axis, want, got);
            mismatch_count++;
        end
    endfunction

    always @(negedge clk)
    begin : result_check
        rotated_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rotated_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = rotated_q.pop_front();
                compare_coord("rotated_x", want.rx, m_tdata[COORD_W-1:0]);
                compare_coord("rotated_y", want.ry, m_tdata[2*COORD_W-1:COORD_W]);
                compare_coord("rotated_z", want.rz, m_tdata[3*COORD_W-1:2*COORD_W]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n    = 1'b1;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        build_sine_table();
        // a clean falling edge after time zero so the async clear always fires
        #1 rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_axis_quadrants();
        test_angle_wrap();
        test_saturation();
        test_rounding();
        test_random_rotations();
        test_drain_pause();
        test_full_rate();

        // let the pipeline empty, then a little extra for stray beats
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** euler_xyz_point_rotation_top: PASSED **");
        else
            $display("** euler_xyz_point_rotation_top: FAILED **");
        $finish;
    end

endmodule
